### src/lwps_pkg.sv
// ----------------------------------------------------------------------------
// lwps_pkg
// Shared types, codes and the RGB565 conversion of the LCD window streamer.
// ----------------------------------------------------------------------------
package lwps_pkg;

	// panel geometry defaults
	localparam int unsigned PANEL_LONG_DEFAULT  = 161;
	localparam int unsigned PANEL_SHORT_DEFAULT = 130;

	// address offsets per orientation
	localparam logic [8:0] COL_OFFSET_PORTRAIT  = 9'd2;
	localparam logic [8:0] ROW_OFFSET_PORTRAIT  = 9'd1;
	localparam logic [8:0] COL_OFFSET_LANDSCAPE = 9'd1;
	localparam logic [8:0] ROW_OFFSET_LANDSCAPE = 9'd2;

	// panel opcodes
	localparam logic [7:0] OP_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] OP_ROW_SET      = 8'h2B;
	localparam logic [7:0] OP_MEMORY_WRITE = 8'h2C;

	// input command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_ORIENTATION   = 3'd0;
	localparam logic [2:0] REG_WINDOW_X      = 3'd1;
	localparam logic [2:0] REG_WINDOW_Y      = 3'd2;
	localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd3;
	localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd4;
	localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd5;
	localparam logic [2:0] REG_FORE_COLOUR   = 3'd6;
	localparam logic [2:0] REG_BACK_COLOUR   = 3'd7;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// descriptor queue depth
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// last byte index of a start sequence and of a pixel
	localparam logic [3:0] START_LAST_IDX = 4'd10;
	localparam logic [3:0] PIXEL_LAST_IDX = 4'd1;

	typedef enum logic [1:0] {
		FMT_RGB565 = 2'd0,
		FMT_GREY8  = 2'd1,
		FMT_RGB888 = 2'd2,
		FMT_MASK   = 2'd3
	} pixel_format_t;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_PIXEL = 1'b1
	} item_kind_t;

	// one queued unit of work for the byte emitter
	// start: arg = {x0, x_end, y0, y_end}; pixel: arg[15:0] = colour
	typedef struct packed {
		item_kind_t  kind;
		logic [31:0] arg;
	} desc_t;

	function automatic logic [15:0] to_rgb565(
		input pixel_format_t fmt,
		input logic [23:0]   p,
		input logic [15:0]   fore,
		input logic [15:0]   back
	);
		logic [15:0] c;
		case (fmt)
			FMT_RGB565: c = p[15:0];
			FMT_GREY8:  c = {p[7:3], p[7:2], p[7:3]};
			FMT_RGB888: c = {p[23:19], p[15:10], p[7:3]};
			FMT_MASK:   c = p[0] ? fore : back;
			default:    c = p[15:0];
		endcase
		return c;
	endfunction

endpackage

### src/lwps_if.sv
// ----------------------------------------------------------------------------
// lwps interfaces
// Valid/ready channels for pixel items, panel bytes and register writes.
// ----------------------------------------------------------------------------
interface lwps_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [23:0] pixel_value;

	modport source (output valid, output cmd, output pixel_value, input ready);
	modport sink (input valid, input cmd, input pixel_value, output ready);
endinterface

interface lwps_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;

	modport source (output valid, output out_byte, output is_data, output last, input ready);
	modport sink (input valid, input out_byte, input is_data, input last, output ready);
endinterface

interface lwps_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/lcd_window_pixel_streamer.sv
// ----------------------------------------------------------------------------
// lcd_window_pixel_streamer
// Window and pixel stream to command/data bytes of a small RGB565 SPI panel.
// ----------------------------------------------------------------------------
// The pixels channel takes one transaction per cycle as long as the 4-entry
// descriptor queue has room; a start transaction is classified at once and, when
// its origin lies on the panel, expands to 11 bytes (column-set, row-set and
// memory-write with their address bytes), while every pixel that falls inside
// the clipped window expands to two data bytes, high byte first. The byte side
// emits one byte per cycle from its output register while the bytes channel is
// ready; that output register is what sets the sustained rate. A byte reaches
// the bytes channel only after its transaction has passed the descriptor queue
// and the output register. Dropped pixels and off-panel starts are taken from
// the pixels channel but produce nothing. Register writes are always taken and
// are meant to happen while the block is idle.
module lcd_window_pixel_streamer #(
	parameter int unsigned PANEL_LONG_SIDE  = lwps_pkg::PANEL_LONG_DEFAULT,
	parameter int unsigned PANEL_SHORT_SIDE = lwps_pkg::PANEL_SHORT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	lwps_in_if.sink     pixels,
	lwps_out_if.source  bytes,
	lwps_cfg_if.sink    cfg
);
	import lwps_pkg::*;

	// front to queue
	logic  q_push;
	desc_t q_desc;
	logic  q_full;

	// queue to back
	desc_t q_head;
	logic  q_empty;
	logic  q_pop;

	// classifier: registers, window state, conversion to RGB565
	lwps_front #(
		.PANEL_LONG_SIDE  (PANEL_LONG_SIDE),
		.PANEL_SHORT_SIDE (PANEL_SHORT_SIDE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_desc (q_desc)
	);

	// decouples item acceptance from byte emission
	lwps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// byte sequencer with output register
	lwps_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (q_pop),
		.bytes  (bytes)
	);

endmodule

### src/lwps_front.sv
// ----------------------------------------------------------------------------
// lwps_front
// Register file, window tracking and item classification; pushes descriptors.
// ----------------------------------------------------------------------------
module lwps_front #(
	parameter int unsigned PANEL_LONG_SIDE  = lwps_pkg::PANEL_LONG_DEFAULT,
	parameter int unsigned PANEL_SHORT_SIDE = lwps_pkg::PANEL_SHORT_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	lwps_in_if.sink           pixels,
	lwps_cfg_if.sink          cfg,
	input  logic              q_full,
	output logic              q_push,
	output lwps_pkg::desc_t   q_desc
);
	import lwps_pkg::*;

	logic [1:0]    orientation_q;
	logic [7:0]    window_x_q;
	logic [7:0]    window_y_q;
	logic [7:0]    window_width_q;
	logic [7:0]    window_height_q;
	pixel_format_t pixel_format_q;
	logic [15:0]   fore_colour_q;
	logic [15:0]   back_colour_q;

	logic        active_q;
	logic [7:0]  visible_q;
	logic [7:0]  column_q;
	logic [15:0] count_q;

	logic        portrait;
	logic [7:0]  pw, ph;
	logic [8:0]  x0, y0;
	logic [9:0]  lim;
	logic [7:0]  vis;
	logic        on_panel;
	logic [15:0] area;
	logic        in_window;
	logic        send_pixel;
	logic [8:0]  column_inc;
	logic        accept;

	assign cfg.ready    = 1'b1;
	assign pixels.ready = !q_full;
	assign accept       = pixels.valid && pixels.ready;

	always_comb begin
		portrait  = !orientation_q[0];
		pw        = portrait ? 8'(PANEL_SHORT_SIDE) : 8'(PANEL_LONG_SIDE);
		ph        = portrait ? 8'(PANEL_LONG_SIDE) : 8'(PANEL_SHORT_SIDE);
		x0        = {1'b0, window_x_q}
		          + (portrait ? COL_OFFSET_PORTRAIT : COL_OFFSET_LANDSCAPE);
		y0        = {1'b0, window_y_q}
		          + (portrait ? ROW_OFFSET_PORTRAIT : ROW_OFFSET_LANDSCAPE);
		on_panel  = (x0 < {1'b0, pw}) && (y0 < {1'b0, ph});
		lim       = {2'b0, pw} - {2'b0, window_x_q}
		          + {1'b0, (portrait ? COL_OFFSET_PORTRAIT : COL_OFFSET_LANDSCAPE)};
		vis       = ({2'b0, window_width_q} < lim) ? window_width_q : lim[7:0];
		area      = {8'b0, window_width_q} * {8'b0, window_height_q};
		in_window = active_q && (count_q < area);
		send_pixel = in_window && (column_q < visible_q);
		column_inc = {1'b0, column_q} + 9'd1;
	end

	always_comb begin
		q_desc.kind = KIND_PIXEL;
		q_desc.arg  = '0;
		q_push      = 1'b0;
		if (pixels.cmd == CMD_START) begin
			q_desc.kind = KIND_START;
			q_desc.arg  = {x0[7:0], 8'(x0[7:0] + window_width_q + 8'hFF),
			               y0[7:0], 8'(y0[7:0] + window_height_q + 8'hFF)};
			q_push      = accept && on_panel;
		end else begin
			q_desc.arg  = {16'b0, to_rgb565(pixel_format_q, pixels.pixel_value,
			                                fore_colour_q, back_colour_q)};
			q_push      = accept && send_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orientation_q   <= '0;
			window_x_q      <= '0;
			window_y_q      <= '0;
			window_width_q  <= 8'd130;
			window_height_q <= 8'd161;
			pixel_format_q  <= FMT_RGB565;
			fore_colour_q   <= 16'hFFFF;
			back_colour_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ORIENTATION:   orientation_q   <= cfg.data[1:0];
				REG_WINDOW_X:      window_x_q      <= cfg.data[7:0];
				REG_WINDOW_Y:      window_y_q      <= cfg.data[7:0];
				REG_WINDOW_WIDTH:  window_width_q  <= cfg.data[7:0];
				REG_WINDOW_HEIGHT: window_height_q <= cfg.data[7:0];
				REG_PIXEL_FORMAT:  pixel_format_q  <= pixel_format_t'(cfg.data[1:0]);
				REG_FORE_COLOUR:   fore_colour_q   <= cfg.data;
				REG_BACK_COLOUR:   back_colour_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			visible_q <= '0;
			column_q  <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (pixels.cmd == CMD_START) begin
				active_q  <= on_panel;
				visible_q <= on_panel ? vis : 8'd0;
				column_q  <= '0;
				count_q   <= '0;
			end else if (in_window) begin
				count_q  <= count_q + 16'd1;
				column_q <= (column_inc >= {1'b0, window_width_q}) ? 8'd0 : column_inc[7:0];
			end
		end
	end

endmodule

### src/lwps_queue.sv
// ----------------------------------------------------------------------------
// lwps_queue
// Small show-ahead descriptor queue between classifier and byte emitter.
// ----------------------------------------------------------------------------
module lwps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lwps_pkg::desc_t push_desc,
	input  logic            pop,
	output lwps_pkg::desc_t head,
	output logic            full,
	output logic            empty
);
	import lwps_pkg::*;

	desc_t                  entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   fill_q;

	assign full  = (fill_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### src/lwps_back.sv
// ----------------------------------------------------------------------------
// lwps_back
// Expands queued descriptors into panel bytes through an output register.
// ----------------------------------------------------------------------------
module lwps_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lwps_pkg::desc_t head,
	input  logic            empty,
	output logic            pop,
	lwps_out_if.source      bytes
);
	import lwps_pkg::*;

	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       data_q;
	logic       last_q;

	logic [7:0] sel_byte;
	logic       sel_data;
	logic       sel_last;
	logic       advance;

	assign bytes.valid    = valid_q;
	assign bytes.out_byte = byte_q;
	assign bytes.is_data  = data_q;
	assign bytes.last     = last_q;

	assign advance = !empty && (!valid_q || bytes.ready);
	assign pop     = advance && sel_last;

	always_comb begin
		sel_byte = '0;
		sel_data = 1'b1;
		sel_last = 1'b0;
		if (head.kind == KIND_PIXEL) begin
			sel_byte = (idx_q == PIXEL_LAST_IDX) ? head.arg[7:0] : head.arg[15:8];
			sel_last = (idx_q == PIXEL_LAST_IDX);
		end else begin
			case (idx_q)
				4'd0: begin
					sel_byte = OP_COLUMN_SET;
					sel_data = 1'b0;
				end
				4'd2: sel_byte = head.arg[31:24];
				4'd4: sel_byte = head.arg[23:16];
				4'd5: begin
					sel_byte = OP_ROW_SET;
					sel_data = 1'b0;
				end
				4'd7: sel_byte = head.arg[15:8];
				4'd9: sel_byte = head.arg[7:0];
				START_LAST_IDX: begin
					sel_byte = OP_MEMORY_WRITE;
					sel_data = 1'b0;
					sel_last = 1'b1;
				end
				default: sel_byte = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= 1'b1;
			idx_q   <= sel_last ? 4'd0 : idx_q + 4'd1;
		end else if (bytes.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= sel_byte;
			data_q <= sel_data;
			last_q <= sel_last;
		end
	end

endmodule

### src/lwps_checker.sv
// ----------------------------------------------------------------------------
// lwps_checker
// Port-level checks on the byte channel of the window streamer.
// ----------------------------------------------------------------------------
module lwps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_is_data,
	input logic       out_last
);
	import lwps_pkg::*;

	// stalled byte stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("byte withdrawn while stalled");

	// stalled byte keeps its payload
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_is_data)
		&& $stable(out_last))
		else $error("byte changed while stalled");

	// only known opcodes go out as commands
	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_is_data |-> out_byte == OP_COLUMN_SET
		|| out_byte == OP_ROW_SET || out_byte == OP_MEMORY_WRITE)
		else $error("unknown command byte");

	// a command closes a transaction only as memory-write
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_is_data && out_last |-> out_byte == OP_MEMORY_WRITE)
		else $error("command marked last is not memory-write");

	// column-set is always followed by an address data byte
	a_col_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_is_data && out_byte == OP_COLUMN_SET
		##1 out_valid |-> out_is_data)
		else $error("column-set not followed by data");

endmodule

bind lcd_window_pixel_streamer lwps_checker u_lwps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (bytes.valid),
	.out_ready   (bytes.ready),
	.out_byte    (bytes.out_byte),
	.out_is_data (bytes.is_data),
	.out_last    (bytes.last)
);
